/* design/lrst_pkg.sv */
`timescale 1ns / 1ps
package lrst_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int TREE_NODES_DEF   = 4096;
    localparam int USED_RESET       = 1024;
    localparam int DATA_W           = 64;
    localparam int IDX_W            = 10;
    localparam int CFG_W            = 11;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_ADD  = 2'd1,
        TAG_SET  = 2'd2
    } t_tag;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_SET   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        t_tag              tk;
        logic [DATA_W-1:0] tv;
    } t_node;

endpackage

/* design/lrst_mem.sv */
`timescale 1ns / 1ps
module lrst_mem
    import lrst_pkg::*;
#(
    parameter int DEPTH = TREE_NODES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_node         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_node         o_rdata
);

    t_node r_mem [DEPTH];
    t_node r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

/* design/lrst_tag.sv */
`timescale 1ns / 1ps
module lrst_tag
    import lrst_pkg::*;
#(
    parameter int LENW = 11
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  t_node             i_node,
    input  t_tag              i_tk,
    input  logic [DATA_W-1:0] i_tv,
    input  logic [LENW-1:0]   i_len,
    output t_node             o_node
);

    t_node                   r_node;
    logic [DATA_W-1:0]       r_prod;
    logic [DATA_W+LENW-1:0]  prod_full;

    assign prod_full = i_tv * i_len;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_node <= i_node;
            r_prod <= prod_full[DATA_W-1:0];
        end
    end

    // set overrides; add stacks onto whatever is pending
    always_comb begin
        o_node = r_node;
        case (i_tk)
            TAG_SET: begin
                o_node.sum = r_prod;
                o_node.tk  = TAG_SET;
                o_node.tv  = i_tv;
            end
            TAG_ADD: begin
                o_node.sum = r_node.sum + r_prod;
                o_node.tv  = r_node.tv + i_tv;
                o_node.tk  = (r_node.tk == TAG_SET) ? TAG_SET : TAG_ADD;
            end
            default: o_node = r_node;
        endcase
    end

endmodule

/* design/lazy_range_add_set_sum_tree_core.sv */
`timescale 1ns / 1ps
// Walk: a partly covered node with a pending tag pushes it to both children (read,
// scale, write each); on an update each partly covered node re-sums its children on
// the way back up. A walk visits at most 39 nodes at 1024 elements. An empty range
// or unused kind never raises busy. The query sum is registered in the done state.
// One request at a time; reset and every used_count write start a clearing pass over
// all TREE_NODES nodes. Results appear for one cycle on o_valid; no receiver stall.
module lazy_range_add_set_sum_tree_core
    import lrst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int TREE_NODES   = TREE_NODES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_kind,
    input  logic [IDX_W-1:0]         i_range_low,
    input  logic [IDX_W-1:0]         i_range_high,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_range_sum,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int EW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LENW = EW + 1;
    localparam int CW   = ((EW > IDX_W) ? EW : IDX_W) + 1;
    localparam int AW   = $clog2(TREE_NODES);
    localparam int PW   = AW + 1;
    localparam int SD   = EW + 1;
    localparam int IW   = $clog2(SD);
    localparam int UW   = (CFG_W > LENW) ? CFG_W : LENW;
    localparam int RESET_USED = (USED_RESET > MAX_ELEMENTS) ? MAX_ELEMENTS : USED_RESET;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VISIT, S_NODE, S_TRD, S_TMUL, S_TWR, S_PUSH2,
        S_PCLR, S_RET, S_RESUME, S_SUM, S_SUM2, S_SUM3, S_DONE
    } t_state;

    t_state              r_state, r_tret;
    logic [AW-1:0]       r_clr;
    logic [EW-1:0]       r_last;
    logic [1:0]          r_kind;
    logic [CW-1:0]       r_a, r_b;
    logic [DATA_W-1:0]   r_val, r_acc, r_psum, r_lsum;
    logic [PW-1:0]       r_p, r_t;
    logic [EW-1:0]       r_lo, r_hi;
    logic [IW-1:0]       r_lvl;
    logic [EW-1:0]       r_lo_s [SD];
    logic [EW-1:0]       r_hi_s [SD];
    logic                r_ph_s [SD];
    t_tag                r_tk;
    logic [DATA_W-1:0]   r_tv;
    logic [LENW-1:0]     r_len;

    logic [EW:0]         lh_sum;
    logic [EW-1:0]       mid;
    logic [CW-1:0]       lo_x, hi_x;
    logic                disjoint, covered, is_upd;
    logic [PW-1:0]       p_l, p_r;
    logic [UW-1:0]       cfg_v, cfg_c;
    logic [IW-1:0]       lvl_up;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    t_node               mem_wdata, mem_rdata, tag_out;

    assign lh_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = lh_sum[EW:1];
    assign lo_x     = CW'(r_lo);
    assign hi_x     = CW'(r_hi);
    assign disjoint = (r_b < lo_x) || (r_a > hi_x) || (r_p >= PW'(TREE_NODES));
    assign covered  = (r_a <= lo_x) && (hi_x <= r_b);
    assign is_upd   = (r_kind != KIND_QUERY);
    assign p_l      = {r_p[PW-2:0], 1'b0};
    assign p_r      = {r_p[PW-2:0], 1'b1};
    assign lvl_up   = r_lvl - 1'b1;

    assign cfg_v = UW'(i_cfg_data);
    always_comb begin
        cfg_c = cfg_v;
        if (cfg_v == '0) cfg_c = UW'(1);
        if (cfg_v > UW'(MAX_ELEMENTS)) cfg_c = UW'(MAX_ELEMENTS);
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    always_comb begin
        case (r_state)
            S_TRD:   mem_raddr = r_t[AW-1:0];
            S_SUM:   mem_raddr = p_l[AW-1:0];
            S_SUM2:  mem_raddr = p_r[AW-1:0];
            default: mem_raddr = r_p[AW-1:0];
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p[AW-1:0];
        mem_wdata = '{sum: r_psum, tk: TAG_NONE, tv: '0};
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '{sum: '0, tk: TAG_NONE, tv: '0};
            end
            S_TWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_t[AW-1:0];
                mem_wdata = tag_out;
            end
            S_PCLR: mem_we = 1'b1;
            S_SUM3: begin
                mem_we    = 1'b1;
                mem_wdata = '{sum: r_lsum + ((p_r < PW'(TREE_NODES)) ? mem_rdata.sum : '0),
                              tk: TAG_NONE, tv: '0};
            end
            default: mem_we = 1'b0;
        endcase
    end

    lrst_mem #(.DEPTH(TREE_NODES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lrst_tag #(.LENW(LENW)) u_tag (
        .i_clk  (i_clk),
        .i_en   (r_state == S_TMUL),
        .i_node (mem_rdata),
        .i_tk   (r_tk),
        .i_tv   (r_tv),
        .i_len  (r_len),
        .o_node (tag_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_last  <= EW'(RESET_USED - 1);
            r_lvl   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(TREE_NODES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_last  <= EW'(cfg_c - UW'(1));
                        r_clr   <= '0;
                        r_state <= S_CLEAR;
                    end else if (start) begin
                        r_kind <= i_kind;
                        r_a    <= CW'(i_range_low);
                        r_b    <= CW'(i_range_high);
                        r_val  <= i_value;
                        r_acc  <= '0;
                        r_p    <= PW'(1);
                        r_lo   <= '0;
                        r_hi   <= r_last;
                        r_lvl  <= '0;
                        if (i_kind == KIND_NOP) begin
                            r_state <= S_IDLE;
                        end else if (i_range_low > i_range_high) begin
                            if (i_kind == KIND_QUERY) begin
                                o_valid     <= 1'b1;
                                o_range_sum <= '0;
                            end
                        end else begin
                            r_state <= S_VISIT;
                        end
                    end
                end
                S_VISIT: r_state <= disjoint ? S_RET : S_NODE;
                S_NODE: begin
                    if (covered) begin
                        if (!is_upd) begin
                            r_acc   <= r_acc + mem_rdata.sum;
                            r_state <= S_RET;
                        end else begin
                            r_tk    <= (r_kind == KIND_SET) ? TAG_SET : TAG_ADD;
                            r_tv    <= r_val;
                            r_t     <= r_p;
                            r_len   <= LENW'(r_hi) - LENW'(r_lo) + 1'b1;
                            r_tret  <= S_RET;
                            r_state <= S_TRD;
                        end
                    end else begin
                        r_psum <= mem_rdata.sum;
                        r_tk   <= mem_rdata.tk;
                        r_tv   <= mem_rdata.tv;
                        if (mem_rdata.tk == TAG_NONE) begin
                            r_lo_s[r_lvl] <= r_lo;
                            r_hi_s[r_lvl] <= r_hi;
                            r_ph_s[r_lvl] <= 1'b0;
                            r_lvl   <= r_lvl + 1'b1;
                            r_p     <= p_l;
                            r_hi    <= mid;
                            r_state <= S_VISIT;
                        end else begin
                            r_t     <= p_l;
                            r_len   <= LENW'(mid) - LENW'(r_lo) + 1'b1;
                            r_tret  <= S_PUSH2;
                            r_state <= S_TRD;
                        end
                    end
                end
                S_TRD:  r_state <= (r_t >= PW'(TREE_NODES)) ? r_tret : S_TMUL;
                S_TMUL: r_state <= S_TWR;
                S_TWR:  r_state <= r_tret;
                S_PUSH2: begin
                    r_t     <= p_r;
                    r_len   <= LENW'(r_hi) - LENW'(mid);
                    r_tret  <= S_PCLR;
                    r_state <= S_TRD;
                end
                S_PCLR: begin
                    r_lo_s[r_lvl] <= r_lo;
                    r_hi_s[r_lvl] <= r_hi;
                    r_ph_s[r_lvl] <= 1'b0;
                    r_lvl   <= r_lvl + 1'b1;
                    r_p     <= p_l;
                    r_hi    <= mid;
                    r_state <= S_VISIT;
                end
                S_RET: begin
                    if (r_lvl == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lvl   <= lvl_up;
                        r_p     <= r_p >> 1;
                        r_lo    <= r_lo_s[lvl_up];
                        r_hi    <= r_hi_s[lvl_up];
                        r_state <= S_RESUME;
                    end
                end
                S_RESUME: begin
                    if (!r_ph_s[r_lvl]) begin
                        r_ph_s[r_lvl] <= 1'b1;
                        r_lvl   <= r_lvl + 1'b1;
                        r_p     <= p_r;
                        r_lo    <= mid + 1'b1;
                        r_state <= S_VISIT;
                    end else begin
                        r_state <= is_upd ? S_SUM : S_RET;
                    end
                end
                S_SUM:  r_state <= S_SUM2;
                S_SUM2: begin
                    r_lsum  <= (p_l < PW'(TREE_NODES)) ? mem_rdata.sum : '0;
                    r_state <= S_SUM3;
                end
                S_SUM3: r_state <= S_RET;
                S_DONE: begin
                    if (!is_upd) begin
                        o_valid     <= 1'b1;
                        o_range_sum <= r_acc;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* sim/lrst_checker.sv */
`timescale 1ns / 1ps
module lrst_checker
    import lrst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               i_kind,
    input  logic [IDX_W-1:0]         i_range_low,
    input  logic [IDX_W-1:0]         i_range_high,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     o_valid,
    input  logic signed [DATA_W-1:0] o_range_sum,
    input  logic                     i_cfg_valid,
    input  logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output int                       o_fail_count,
    output int                       o_sums_pending,
    output int                       o_requests_seen,
    output int                       o_sums_checked
);

    // Flat element image: the tree sums are exact modulo 2^64, so a plain
    // array gives the same answers as the lazy walk.
    logic [DATA_W-1:0] elem_val [0:MAX_ELEMENTS_DEF-1];
    int unsigned       span;
    logic [DATA_W-1:0] sum_queue [$];

    function automatic int unsigned clamp_span(logic [CFG_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
        return int'(w);
    endfunction

    task automatic clear_elems();
        for (int i = 0; i < MAX_ELEMENTS_DEF; i++) elem_val[i] = '0;
    endtask

    task automatic apply_request(t_kind k, int unsigned lo, int unsigned hi,
                                 logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int unsigned i = lo; i <= hi && i < span; i++) begin
            case (k)
                KIND_ADD:   elem_val[i] = elem_val[i] + v;
                KIND_SET:   elem_val[i] = v;
                KIND_QUERY: acc = acc + elem_val[i];
                default: ;
            endcase
        end
        if (k == KIND_QUERY) sum_queue.push_back(acc);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span = USED_RESET;
            clear_elems();
            sum_queue.delete();
            o_fail_count    <= 0;
            o_requests_seen <= 0;
            o_sums_checked  <= 0;
        end else begin
            if (o_valid) begin
                if (sum_queue.size() == 0) begin
                    $error("range_sum: unexpected result %0h", o_range_sum);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    logic [DATA_W-1:0] want;
                    want = sum_queue.pop_front();
                    if (want !== o_range_sum) begin
                        $error("range_sum: expected %0h actual %0h", want, o_range_sum);
                        o_fail_count <= o_fail_count + 1;
                    end
                    o_sums_checked <= o_sums_checked + 1;
                end
            end
            if (start && !busy) begin
                apply_request(t_kind'(i_kind), int'(i_range_low), int'(i_range_high),
                              i_value);
                o_requests_seen <= o_requests_seen + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                span = clamp_span(i_cfg_data);
                clear_elems();
            end
        end
        o_sums_pending <= sum_queue.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import lrst_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               i_kind = KIND_NOP;
    logic [IDX_W-1:0]         i_range_low = '0;
    logic [IDX_W-1:0]         i_range_high = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_range_sum;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    int fail_count, sums_pending, requests_seen, sums_checked;
    int cycle_count = 0;
    int idle_pct = 0;
    int span_now = USED_RESET;

    always #4 i_clk = ~i_clk;

    lazy_range_add_set_sum_tree_core dut (.*);

    lrst_checker checker_i (
        .*,
        .o_fail_count   (fail_count),
        .o_sums_pending (sums_pending),
        .o_requests_seen(requests_seen),
        .o_sums_checked (sums_checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lazy_range_add_set_sum_tree_core] ERROR");
            $finish;
        end
    end

    task automatic send(t_kind k, int lo, int hi, logic [DATA_W-1:0] v);
        start        <= 1'b1;
        i_kind       <= k;
        i_range_low  <= IDX_W'(lo);
        i_range_high <= IDX_W'(hi);
        i_value      <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sums_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_span(logic [CFG_W-1:0] w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        span_now = (w == 0) ? 1 : (w > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(w);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return {1'b0, {63{1'b1}}};
            1: return {1'b1, 63'b0};
            2: return DATA_W'($urandom_range(100)) - 50;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_item();
        int lo, hi, r;
        t_kind k;
        r = $urandom_range(99);
        k = (r < 35) ? KIND_ADD : (r < 60) ? KIND_SET : (r < 95) ? KIND_QUERY : KIND_NOP;
        r = $urandom_range(99);
        if (r < 80) begin
            lo = $urandom_range(span_now - 1);
            hi = $urandom_range(span_now - 1, lo);
        end else begin
            lo = $urandom_range(1023);
            hi = $urandom_range(1023);
        end
        send(k, lo, hi, pick_value());
    endtask

    initial begin
        int spans[5] = '{1000, 37, 2, 200, 1024};
        int idles[5] = '{0, 56, 17, 0, 56};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, wrap, empty and past-end ranges, unused kind
        send(KIND_SET, 0, 1023, {1'b0, {63{1'b1}}});
        send(KIND_QUERY, 0, 1023, '0);
        send(KIND_ADD, 0, 1023, {1'b1, 63'b0});
        send(KIND_QUERY, 0, 1023, '0);
        send(KIND_ADD, 5, 3, 64'd7);
        send(KIND_QUERY, 5, 3, '0);
        send(KIND_SET, 1023, 1023, 64'd42);
        send(KIND_QUERY, 1023, 1023, '0);
        send(KIND_NOP, 0, 1023, '1);
        send(KIND_SET, 10, 10, -64'sd3);
        send(KIND_ADD, 0, 511, 64'd1);
        send(KIND_QUERY, 9, 11, '0);
        send(KIND_QUERY, 512, 1023, '0);
        write_span(11'h7ff);
        send(KIND_SET, 0, 1023, 64'd5);
        send(KIND_QUERY, 0, 0, '0);
        write_span(11'd0);
        send(KIND_ADD, 0, 1023, 64'd9);
        send(KIND_QUERY, 0, 1023, '0);
        send(KIND_QUERY, 1, 1023, '0);
        send(KIND_SET, 1, 1023, 64'd4);
        send(KIND_QUERY, 0, 0, '0);

        foreach (spans[p]) begin
            write_span(CFG_W'(spans[p]));
            idle_pct = idles[p];
            for (int i = 0; i < 345; i++) random_item();
        end

        drain();
        $display("Ran %0d requests over spans 1..1024 with idle mixes; %0d sums checked.",
                 requests_seen, sums_checked);
        if (fail_count == 0) begin
            $display("[lazy_range_add_set_sum_tree_core] OK");
        end else begin
            $display("[lazy_range_add_set_sum_tree_core] ERROR");
        end
        $finish;
    end

endmodule
